FILE: rtl/core/shamh_pkg.sv
// ----------------------------------------------------------------------------
// shamh_pkg
// Shared types, sizes and constant tables for the SHA-256 message hasher:
// controller state, control bundles between the units, round constants and
// initial hash values.
// ----------------------------------------------------------------------------
package shamh_pkg;

    localparam int BLK_WORDS  = 16;
    localparam int HASH_WORDS = 8;
    localparam int ROUNDS     = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT
    } t_state;

    // controls for the round unit and its block memory
    typedef struct packed {
        logic        blk_we;
        logic [3:0]  blk_waddr;
        logic [31:0] blk_wdata;
        logic [3:0]  blk_raddr;
        logic        load_shift;
        logic        w_load;
        logic        round_en;
        logic [5:0]  round_idx;
        logic        upd_rot;
    } t_rnd_ctl;

    // controls for the hash word memory
    typedef struct packed {
        logic       rd_en;
        logic [2:0] rd_addr;
        logic       wr_en;
        logic [2:0] wr_addr;
        logic       clear;
    } t_hash_ctl;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf5;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

FILE: rtl/core/shamh_round.sv
// ----------------------------------------------------------------------------
// shamh_round
// Block memory (16 message words), message schedule window and the eight
// working variables, updated by a compression round computed combinationally.
// ----------------------------------------------------------------------------
module shamh_round import shamh_pkg::*; (
    input  logic        i_clk,
    input  t_rnd_ctl    i_ctl,
    input  logic [31:0] i_hash_word,
    output logic [31:0] o_var_a
);

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    logic [31:0] r_blk_mem [BLK_WORDS];
    logic [31:0] r_blk_rd;
    logic [31:0] r_win [BLK_WORDS];
    logic [31:0] r_w;
    logic [31:0] n_w;
    logic [31:0] r_var [HASH_WORDS];

    logic [31:0] s1, ch, t1, s0, mj, t2, sg0, sg1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.blk_we) begin
            r_blk_mem[i_ctl.blk_waddr] <= i_ctl.blk_wdata;
        end
        r_blk_rd <= r_blk_mem[i_ctl.blk_raddr];
    end

    always_comb begin
        s1  = ror(r_var[4], 6) ^ ror(r_var[4], 11) ^ ror(r_var[4], 25);
        ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        t1  = r_var[7] + s1 + ch + round_k(i_ctl.round_idx) + r_w;
        s0  = ror(r_var[0], 2) ^ ror(r_var[0], 13) ^ ror(r_var[0], 22);
        mj  = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t2  = s0 + mj;
        // window holds W[r-16] .. W[r-1]; build W[r+1] one round ahead
        sg0 = ror(r_win[2], 7) ^ ror(r_win[2], 18) ^ (r_win[2] >> 3);
        sg1 = ror(r_win[BLK_WORDS-1], 17) ^ ror(r_win[BLK_WORDS-1], 19)
            ^ (r_win[BLK_WORDS-1] >> 10);
        if (i_ctl.round_idx < 6'(BLK_WORDS - 1)) begin
            n_w = r_blk_rd;
        end else begin
            n_w = sg1 + r_win[10] + sg0 + r_win[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_shift) begin
            for (int i = 0; i < HASH_WORDS - 1; i++) begin
                r_var[i] <= r_var[i+1];
            end
            r_var[HASH_WORDS-1] <= i_hash_word;
        end else if (i_ctl.upd_rot) begin
            for (int i = 0; i < HASH_WORDS - 1; i++) begin
                r_var[i] <= r_var[i+1];
            end
            r_var[HASH_WORDS-1] <= r_var[0];
        end else if (i_ctl.round_en) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= t1 + t2;
        end

        if (i_ctl.w_load) begin
            r_w <= r_blk_rd;
        end else if (i_ctl.round_en) begin
            r_w <= n_w;
        end

        if (i_ctl.round_en) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[BLK_WORDS-1] <= r_w;
        end
    end

    assign o_var_a = r_var[0];

endmodule

FILE: rtl/core/shamh_hash_mem.sv
// ----------------------------------------------------------------------------
// shamh_hash_mem
// Eight-word hash memory with registered read. Per-word valid bits
// make an unwritten word read as its initial hash value; the write port adds
// the working variable to the word just read.
// ----------------------------------------------------------------------------
module shamh_hash_mem import shamh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_hash_ctl   i_ctl,
    input  logic [31:0] i_add_word,
    output logic [31:0] o_rd_word
);

    logic [31:0]           r_mem [HASH_WORDS];
    logic [HASH_WORDS-1:0] r_vld;
    logic [31:0]           r_rd_data;
    logic                  r_rd_vld;
    logic [2:0]            r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= o_rd_word + i_add_word;
        end
        // hold the read word while nothing new is requested
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
            r_rd_vld  <= r_vld[i_ctl.rd_addr];
            r_rd_addr <= i_ctl.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_ctl.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_word = r_rd_vld ? r_rd_data : init_h(r_rd_addr);

endmodule

FILE: rtl/core/shamh_ctrl.sv
// ----------------------------------------------------------------------------
// shamh_ctrl
// Sequencer: gathers bytes into block words, sweeps the padding words,
// steps hash load, 64 rounds and hash update, and hands out the digest.
// ----------------------------------------------------------------------------
module shamh_ctrl import shamh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output t_rnd_ctl    o_rnd_ctl,
    output t_hash_ctl   o_hash_ctl
);

    t_state      r_state, n_state;
    logic [60:0] r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_seq, n_seq;
    logic [3:0]  r_wi, n_wi;
    logic [2:0]  r_idx, n_idx;
    logic        r_pend_end, n_pend_end;
    logic        r_second, n_second;
    logic        r_last, n_last;

    logic [5:0]  pos;
    logic [1:0]  lane;
    logic        extra;
    logic        len_ok;
    logic [31:0] partial;
    logic [31:0] pad_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_seq      <= '0;
            r_wi       <= '0;
            r_idx      <= '0;
            r_pend_end <= 1'b0;
            r_second   <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_seq      <= n_seq;
            r_wi       <= n_wi;
            r_idx      <= n_idx;
            r_pend_end <= n_pend_end;
            r_second   <= n_second;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // padding word at the current sweep position
    always_comb begin
        pos    = r_cnt[5:0];
        lane   = r_cnt[1:0];
        extra  = (pos[5:3] == 3'b111);
        len_ok = r_second || !extra;
        case (lane)
            2'd0:    partial = 32'h8000_0000;
            2'd1:    partial = {r_acc[31:24], 24'h80_0000};
            2'd2:    partial = {r_acc[31:16], 16'h8000};
            default: partial = {r_acc[31:8], 8'h80};
        endcase
        if (!r_second && (r_wi == pos[5:2])) begin
            pad_val = partial;
        end else if (len_ok && (r_wi == 4'd14)) begin
            pad_val = r_cnt[60:29];
        end else if (len_ok && (r_wi == 4'd15)) begin
            pad_val = {r_cnt[28:0], 3'b000};
        end else begin
            pad_val = '0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_seq      = r_seq;
        n_wi       = r_wi;
        n_idx      = r_idx;
        n_pend_end = r_pend_end;
        n_second   = r_second;
        n_last     = r_last;

        o_rnd_ctl           = '0;
        o_rnd_ctl.round_idx = r_seq;
        o_hash_ctl          = '0;
        o_valid             = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_has_byte) begin
                        unique case (lane)
                            2'd0: n_acc[31:24] = i_data_byte;
                            2'd1: n_acc[23:16] = i_data_byte;
                            2'd2: n_acc[15:8]  = i_data_byte;
                            2'd3: n_acc[7:0]   = i_data_byte;
                        endcase
                        o_rnd_ctl.blk_we    = (lane == 2'd3);
                        o_rnd_ctl.blk_waddr = pos[5:2];
                        o_rnd_ctl.blk_wdata = {r_acc[31:8], i_data_byte};
                        n_cnt = r_cnt + 61'd1;
                    end
                    if (i_has_byte && (pos == 6'd63)) begin
                        n_state    = ST_LOAD;
                        n_seq      = '0;
                        n_pend_end = i_end_of_message;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                        n_wi    = n_cnt[5:2];
                    end
                end
            end
            ST_PAD: begin
                o_rnd_ctl.blk_we    = 1'b1;
                o_rnd_ctl.blk_waddr = r_wi;
                o_rnd_ctl.blk_wdata = pad_val;
                if (r_wi == 4'(BLK_WORDS - 1)) begin
                    if (!r_second && extra) begin
                        // no room for the length: pad a second block after this one
                        n_second   = 1'b1;
                        n_pend_end = 1'b1;
                    end else begin
                        n_last     = 1'b1;
                        n_pend_end = 1'b0;
                    end
                    n_state = ST_LOAD;
                    n_seq   = '0;
                end else begin
                    n_wi = r_wi + 4'd1;
                end
            end
            ST_LOAD: begin
                // read hash words 0..7, shift each into the working variables
                o_hash_ctl.rd_en     = !r_seq[3];
                o_hash_ctl.rd_addr   = r_seq[2:0];
                o_rnd_ctl.load_shift = (r_seq != 6'd0);
                o_rnd_ctl.blk_raddr  = r_seq[3] ? 4'd1 : 4'd0;
                o_rnd_ctl.w_load     = r_seq[3];
                if (r_seq[3]) begin
                    n_state = ST_ROUND;
                    n_seq   = '0;
                end else begin
                    n_seq = r_seq + 6'd1;
                end
            end
            ST_ROUND: begin
                o_rnd_ctl.round_en  = 1'b1;
                o_rnd_ctl.blk_raddr = r_seq[3:0] + 4'd2;
                if (r_seq == 6'(ROUNDS - 1)) begin
                    n_state = ST_UPDATE;
                    n_seq   = '0;
                end else begin
                    n_seq = r_seq + 6'd1;
                end
            end
            ST_UPDATE: begin
                // read word j, write word j-1 back with its working variable added
                o_hash_ctl.rd_en    = !r_seq[3];
                o_hash_ctl.rd_addr  = r_seq[2:0];
                o_hash_ctl.wr_en    = (r_seq != 6'd0);
                o_hash_ctl.wr_addr  = r_seq[2:0] - 3'd1;
                o_rnd_ctl.upd_rot   = (r_seq != 6'd0);
                if (r_seq[3]) begin
                    n_seq = '0;
                    if (r_last) begin
                        n_state = ST_OUT_RD;
                        n_idx   = '0;
                    end else if (r_pend_end) begin
                        n_state = ST_PAD;
                        n_wi    = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_seq = r_seq + 6'd1;
                end
            end
            ST_OUT_RD: begin
                o_hash_ctl.rd_en   = 1'b1;
                o_hash_ctl.rd_addr = r_idx;
                n_state            = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (r_idx == 3'd7) begin
                        // digest done: back to the start state
                        o_hash_ctl.clear = 1'b1;
                        n_cnt      = '0;
                        n_last     = 1'b0;
                        n_second   = 1'b0;
                        n_pend_end = 1'b0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

endmodule

FILE: rtl/core/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream. Input transactions carry an optional byte and
// an end-of-message flag; the output channel returns the eight digest words,
// word 0 first, last_word set on word 7.
// Byte transactions are taken while o_stall is low. The 64th byte of a block
// starts a compression (eight hash memory reads, 64 rounds, eight
// read-add-write updates of the hash memory), during which o_stall is high.
// An end transaction writes the rest of the block with padding words, then
// compresses; with 56 or more bytes in the block a second padded block
// follows and is compressed. After the last compression each digest word is
// read in ST_OUT_RD and shown in ST_OUT; the next follows once i_stall is low.
// i_stall holds the current word; no input is taken until all eight are out.
// Reset restores the initial hash values and clears the byte count.
// ----------------------------------------------------------------------------
module sha256_message_hasher import shamh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_rnd_ctl    rnd_ctl;
    t_hash_ctl   hash_ctl;
    logic [31:0] hash_word;
    logic [31:0] var_a;

    shamh_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .o_rnd_ctl        (rnd_ctl),
        .o_hash_ctl       (hash_ctl)
    );

    shamh_round u_round (
        .i_clk       (i_clk),
        .i_ctl       (rnd_ctl),
        .i_hash_word (hash_word),
        .o_var_a     (var_a)
    );

    shamh_hash_mem u_hash_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (hash_ctl),
        .i_add_word (var_a),
        .o_rd_word  (hash_word)
    );

    assign o_digest_word = hash_word;

endmodule

FILE: rtl/core/shamh_checker.sv
// ----------------------------------------------------------------------------
// shamh_checker
// Port-level checks on the hasher: input is held off while the digest is
// out, digest words step in order, and the block reopens after the last word.
// ----------------------------------------------------------------------------
module shamh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_end_of_message,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    a_no_input_during_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while digest is presented");

    a_end_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_end_of_message) |=> o_stall)
        else $error("end of message did not close the input");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word)
            |-> ##2 (o_valid && (o_word_index == $past(o_word_index, 2) + 3'd1)))
        else $error("digest word index did not advance by one");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> (!o_stall && !o_valid))
        else $error("block not idle after the last digest word");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall)
            |=> (o_valid && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("stalled digest transaction changed");

endmodule

bind sha256_message_hasher shamh_checker u_shamh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .i_end_of_message (i_end_of_message),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_digest_word    (o_digest_word),
    .o_word_index     (o_word_index),
    .o_last_word      (o_last_word)
);

FILE: dv/sha256_message_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_tb
// Drives byte and end-of-message transactions into the hasher and checks
// every digest word against a SHA-256 predictor kept in the bench. Directed
// messages first (empty, byte with end, end after bytes, empty items), then
// random messages around the padding boundaries under three idling patterns.
// ----------------------------------------------------------------------------
module sha256_message_hasher_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 250;
    localparam int PHASE_ITEMS = 60;

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf5, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:7][31:0] CHAIN_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_txn;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_end_of_message;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // predictor state
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    logic [60:0] msg_len;

    t_digest_txn expected_digest_q [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    sha256_message_hasher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha_restart();
        int j;
        for (j = 0; j < 8; j++) chain_h[j] = CHAIN_IV[j];
        for (j = 0; j < 64; j++) blk_bytes[j] = 8'h00;
        msg_len = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int j;
        for (j = 0; j < 16; j++) begin
            sched[j] = {blk_bytes[4*j], blk_bytes[4*j+1], blk_bytes[4*j+2], blk_bytes[4*j+3]};
        end
        for (j = 16; j < 64; j++) begin
            sched[j] = sched[j-16] + sched[j-7]
                     + (rotr(sched[j-15], 7) ^ rotr(sched[j-15], 18) ^ (sched[j-15] >> 3))
                     + (rotr(sched[j-2], 17) ^ rotr(sched[j-2], 19) ^ (sched[j-2] >> 10));
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (j = 0; j < 64; j++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[j] + sched[j];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    // Take one accepted transaction; on end of message queue the eight words.
    function automatic void sha_absorb(input logic [7:0] data, input logic has,
                                       input logic eom);
        logic [5:0]  fill;
        logic [63:0] bit_len;
        t_digest_txn txn;
        int i;
        if (has) begin
            fill = msg_len[5:0];
            blk_bytes[fill] = data;
            msg_len = msg_len + 61'd1;
            if (fill == 6'd63) sha_compress();
        end
        if (eom) begin
            fill = msg_len[5:0];
            blk_bytes[fill] = 8'h80;
            for (i = int'(fill) + 1; i < 64; i++) blk_bytes[i] = 8'h00;
            // no room for the length: flush this block and pad a fresh one
            if (fill >= 6'd56) begin
                sha_compress();
                for (i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
            end
            bit_len = {msg_len, 3'b000};
            for (i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
            sha_compress();
            for (i = 0; i < 8; i++) begin
                txn.digest_word = chain_h[i];
                txn.word_index  = 3'(i);
                txn.last_word   = (i == 7);
                expected_digest_q.push_back(txn);
            end
            sha_restart();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_digest_txn want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_digest_q.size() == 0) begin
                report_mismatch("unexpected digest word", o_digest_word, 32'h0);
            end else begin
                want = expected_digest_q.pop_front();
                if (o_digest_word !== want.digest_word)
                    report_mismatch("digest_word", o_digest_word, want.digest_word);
                if (o_word_index !== want.word_index)
                    report_mismatch("word_index", 32'(o_word_index), 32'(want.word_index));
                if (o_last_word !== want.last_word)
                    report_mismatch("last_word", 32'(o_last_word), 32'(want.last_word));
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("sha256_message_hasher_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_has_byte       <= has;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sha_absorb(data, has, eom);
    endtask

    // Hold the sender off until every digest word has come back.
    task automatic wait_digest_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_digest_q.size() != 0) @(posedge i_clk);
    endtask

    // Random bytes, with empty transactions sprinkled in; the end either rides
    // on the last byte or follows as a transaction of its own.
    task automatic send_message(input int len, input bit join_end, output int items);
        int k;
        items = 0;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, join_end && (k == len - 1));
            items++;
        end
        if (!join_end || len == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            items++;
        end
    endtask

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        wait_digest_drained();
    endtask

    task automatic test_byte_with_end();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_end_after_bytes();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_empty_items();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b0);
        send_item(8'h3c, 1'b1, 1'b1);
        wait_digest_drained();
    endtask

    task automatic test_random_messages(input int sender_pct, input int receiver_pct,
                                        input int boundary_len, input bit boundary_join);
        int phase_items;
        int items;
        int len;
        int pick;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        send_message(boundary_len, boundary_join, items);
        phase_items = items;
        while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 16);
            else if (pick < 9)
                len = $urandom_range(52, 66);
            else
                len = $urandom_range(100, 130);
            send_message(len, $urandom_range(0, 1), items);
            phase_items += items;
        end
        wait_digest_drained();
    endtask

    initial begin
        error_count      = 0;
        send_idle_pct    = 20;
        recv_stall_pct   = 57;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'h00;
        i_has_byte       <= 1'b0;
        i_end_of_message <= 1'b0;
        i_stall          <= 1'b0;
        sha_restart();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_byte_with_end();
        test_end_after_bytes();
        test_empty_items();

        // boundary lengths: two-block pad, one-block pad with joined end, last slot
        test_random_messages(20, 57, 56, 1'b0);
        test_random_messages(57, 20, 55, 1'b1);
        test_random_messages(0, 0, 63, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("sha256_message_hasher_tb: clean");
        else
            $display("sha256_message_hasher_tb: errors");
        $finish;
    end

endmodule
